### hw/rtl/drpec_pkg.sv
// shared types, constants and helper functions of the dram row pattern error counter
// no dependencies; imported by every module of the block
package drpec_pkg;

   localparam int FLIP_COUNT_BITS = 32;   // width of the cumulative flip totals
   localparam int ROW_COUNT_BITS  = 16;   // width of the saturating row sum
   localparam int FLIP_OUT_BITS   = 32;   // flip total field width on the result
   localparam int ROW_OUT_BITS    = 16;   // row sum field width on the result
   localparam int BEAT_BITS       = 64;
   localparam int BEAT_BYTES      = BEAT_BITS / 8;
   localparam int BEAT_CNT_BITS   = 7;    // 0..64
   localparam int LINE_CNT_BITS   = 10;
   localparam logic [LINE_CNT_BITS-1:0] LINE_SUM_MAX = '1;
   localparam logic [ROW_COUNT_BITS-1:0] ROW_SUM_MAX = '1;

   localparam int QUEUE_DEPTH     = 2;
   localparam int QPTR_BITS       = 1;
   localparam int QCNT_BITS       = 2;

   localparam int CSR_INDEX_BITS  = 2;
   localparam int CSR_DATA_BITS   = 8;

   typedef enum logic [CSR_INDEX_BITS-1:0] {
      CSR_EXPECTED_PATTERN    = 2'd0,
      CSR_ALTERNATE_LINES     = 2'd1,
      CSR_FIRST_LINE_INVERTED = 2'd2
   } csr_index_type;

   typedef struct packed {
      logic [7:0] pattern;
      logic       alternate;
      logic       first_inv;
   } cfg_type;

   // one classified beat as it travels from front to back
   typedef struct packed {
      logic [BEAT_CNT_BITS-1:0] beat_errors;
      logic [BEAT_CNT_BITS-1:0] z2o;
      logic [BEAT_CNT_BITS-1:0] o2z;
      logic                     line_end;
      logic                     row_done;
      logic                     faulty;
   } beat_type;

   typedef struct packed {
      logic                 full;
      logic                 empty;
      logic [QCNT_BITS-1:0] count;
   } qstat_type;

   typedef struct packed {
      logic [BEAT_CNT_BITS-1:0] beat_errors;
      logic [LINE_CNT_BITS-1:0] line_errors;
      logic [ROW_OUT_BITS-1:0]  row_errors;
      logic                     row_fault;
      logic                     row_done;
      logic [FLIP_OUT_BITS-1:0] z2o;
      logic [FLIP_OUT_BITS-1:0] o2z;
   } rsp_type;

   function automatic logic [3:0] ones8(input logic [7:0] v);
      logic [3:0] n;
      n = '0;
      for (int i = 0; i < 8; i++) begin
         n = n + 4'(v[i]);
      end
      return n;
   endfunction

   // pattern that the first line of a row is checked against
   function automatic logic [7:0] load_pattern(input cfg_type c);
      logic [7:0] p;
      p = c.pattern;
      if (c.alternate && c.first_inv) begin
         p = ~c.pattern;
      end
      return p;
   endfunction

endpackage

### hw/rtl/dram_row_pattern_error_counter.sv
// top level of the dram row pattern error counter: front, beat queue and back
// depends on drpec_pkg, drpec_front, drpec_queue, drpec_back
//
// usage
//  - req channel: one 64-bit read burst beat per request; tlast marks the
//    eighth beat of a cache line, tuser carries row-last-line and line-faulty
//  - rsp channel: one result per request, in order; tlast is row done,
//    tuser is the row fault flag, tdata holds the error counts
//  - csr channel: register writes (pattern, alternation, first line polarity),
//    always ready; only issued while no request is in flight
//  - an accepted request passes through the queue and the back's result register
//  - throughput: one request per cycle while rsp is ready; the popcount of the front
//    end and the accumulators of the back end each handle one beat a cycle
//  - a two-entry queue sits between front and back; when rsp stalls the back
//    holds its result register, the queue fills and req_tready drops once full
//  - reset clears the counts, the queue and the result valid, and loads the
//    register defaults: pattern 0x00, alternation on, first line not inverted
//  - a config write reloads the running pattern but keeps all sums
module dram_row_pattern_error_counter (
   input  logic          clock,
   input  logic          reset,
   // request channel
   input  logic          req_tvalid,
   output logic          req_tready,
   input  logic [63:0]   req_tdata,   // beat_data
   input  logic          req_tlast,   // line_last_beat
   input  logic [1:0]    req_tuser,   // row_last_line, line_faulty
   // result channel
   output logic          rsp_tvalid,
   input  logic          rsp_tready,
   output logic [103:0]  rsp_tdata,   // beat_errors, line_errors, row_errors,
                                      // flips_zero_to_one, flips_one_to_zero, zero fill
   output logic          rsp_tlast,   // row_done
   output logic          rsp_tuser,   // row_fault
   // register write channel
   input  logic          csr_valid,
   output logic          csr_ready,
   input  logic [drpec_pkg::CSR_INDEX_BITS-1:0] csr_index,
   input  logic [drpec_pkg::CSR_DATA_BITS-1:0]  csr_data
);
   import drpec_pkg::*;

   beat_type  front_item;
   beat_type  q_head;
   qstat_type q_stat;
   rsp_type   rsp;
   logic      push;
   logic      pop;
   logic      csr_write;

   // register writes are never held off
   assign csr_ready  = 1'b1;
   assign csr_write  = csr_valid & csr_ready;

   // accept while the queue has a free slot
   assign req_tready = !q_stat.full;
   assign push       = req_tvalid & req_tready;

   drpec_front u_front (
      .clock          (clock),
      .reset          (reset),
      .csr_valid      (csr_write),
      .csr_index      (csr_index),
      .csr_data       (csr_data),
      .push           (push),
      .beat_data      (req_tdata),
      .line_last_beat (req_tlast),
      .row_last_line  (req_tuser[0]),
      .line_faulty    (req_tuser[1]),
      .item           (front_item)
   );

   drpec_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_item (front_item),
      .pop       (pop),
      .head      (q_head),
      .stat      (q_stat)
   );

   drpec_back u_back (
      .clock     (clock),
      .reset     (reset),
      .head      (q_head),
      .stat      (q_stat),
      .pop       (pop),
      .rsp_ready (rsp_tready),
      .rsp_valid (rsp_tvalid),
      .rsp       (rsp)
   );

   // pack result fields from the lowest bit up
   assign rsp_tdata = {7'd0, rsp.o2z, rsp.z2o, rsp.row_errors, rsp.line_errors,
                       rsp.beat_errors};
   assign rsp_tlast = rsp.row_done;
   assign rsp_tuser = rsp.row_fault;

`ifndef SYNTHESIS
   // queue occupancy never exceeds its depth
   a_queue_bound: assert property (@(posedge clock) disable iff (reset)
      q_stat.count <= QCNT_BITS'(QUEUE_DEPTH))
      else $error("beat queue overfilled");

   // nothing is pushed into a full queue and nothing is popped from an empty one
   a_queue_flow: assert property (@(posedge clock) disable iff (reset)
      !(push && q_stat.full) && !(pop && q_stat.empty))
      else $error("beat queue push or pop out of turn");

   // a beat can hold at most one error per bit
   a_beat_bound: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tdata[6:0] <= 7'd64))
      else $error("beat error count out of range");

   // no result is shown right after reset
   a_reset_idle: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("result valid after reset");
`endif

endmodule

### hw/rtl/drpec_front.sv
// front end: config registers, running expected pattern and per-beat flip classification
// depends on drpec_pkg
module drpec_front (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 csr_valid,
   input  logic [drpec_pkg::CSR_INDEX_BITS-1:0] csr_index,
   input  logic [drpec_pkg::CSR_DATA_BITS-1:0]  csr_data,
   input  logic                                 push,
   input  logic [drpec_pkg::BEAT_BITS-1:0]      beat_data,
   input  logic                                 line_last_beat,
   input  logic                                 row_last_line,
   input  logic                                 line_faulty,
   output drpec_pkg::beat_type                  item
);
   import drpec_pkg::*;

   cfg_type    cfg_ff, cfg_in;
   logic [7:0] pattern_ff, pattern_in;
   logic [BEAT_BITS-1:0] diff;
   logic [BEAT_CNT_BITS-1:0] z2o_sum, o2z_sum;
   logic [7:0] dbyte;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         case (csr_index)
            CSR_EXPECTED_PATTERN:    cfg_in.pattern   = csr_data;
            CSR_ALTERNATE_LINES:     cfg_in.alternate = csr_data[0];
            CSR_FIRST_LINE_INVERTED: cfg_in.first_inv = csr_data[0];
            default:                 cfg_in = cfg_ff;
         endcase
      end
   end

   always_comb begin
      pattern_in = pattern_ff;
      if (csr_valid && (csr_index inside {CSR_EXPECTED_PATTERN, CSR_ALTERNATE_LINES,
                                          CSR_FIRST_LINE_INVERTED})) begin
         pattern_in = load_pattern(cfg_in);
      end else if (push) begin
         if (line_last_beat && row_last_line) begin
            pattern_in = load_pattern(cfg_ff);
         end else if (line_last_beat && cfg_ff.alternate) begin
            pattern_in = ~pattern_ff;
         end
      end
   end

   // per byte: bits read 1 where 0 expected, and read 0 where 1 expected
   always_comb begin
      diff    = beat_data ^ {BEAT_BYTES{pattern_ff}};
      z2o_sum = '0;
      o2z_sum = '0;
      dbyte   = '0;
      for (int k = 0; k < BEAT_BYTES; k++) begin
         dbyte   = diff[8*k +: 8];
         z2o_sum = z2o_sum + BEAT_CNT_BITS'(ones8(dbyte & ~pattern_ff));
         o2z_sum = o2z_sum + BEAT_CNT_BITS'(ones8(dbyte & pattern_ff));
      end
   end

   always_comb begin
      item.faulty      = line_faulty;
      item.line_end    = line_last_beat;
      item.row_done    = line_last_beat & row_last_line;
      item.z2o         = line_faulty ? '0 : z2o_sum;
      item.o2z         = line_faulty ? '0 : o2z_sum;
      item.beat_errors = line_faulty ? '0 : (z2o_sum + o2z_sum);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff     <= '{pattern: 8'h00, alternate: 1'b1, first_inv: 1'b0};
         pattern_ff <= 8'h00;
      end else begin
         cfg_ff     <= cfg_in;
         pattern_ff <= pattern_in;
      end
   end

endmodule

### hw/rtl/drpec_queue.sv
// short fifo of classified beats between front and back
// depends on drpec_pkg
module drpec_queue (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 push,
   input  drpec_pkg::beat_type  push_item,
   input  logic                 pop,
   output drpec_pkg::beat_type  head,
   output drpec_pkg::qstat_type stat
);
   import drpec_pkg::*;

   beat_type             mem_ff [QUEUE_DEPTH];
   logic [QPTR_BITS-1:0] wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [QCNT_BITS-1:0] count_ff, count_in;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + QCNT_BITS'(1);
      end else if (pop && !push) begin
         count_in = count_ff - QCNT_BITS'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_item;
      end
   end

   assign head       = mem_ff[rd_ptr_ff];
   assign stat.count = count_ff;
   assign stat.full  = (count_ff == QCNT_BITS'(QUEUE_DEPTH));
   assign stat.empty = (count_ff == '0);

endmodule

### hw/rtl/drpec_back.sv
// back end: line, row and flip accumulators plus the result register
// depends on drpec_pkg
module drpec_back (
   input  logic                 clock,
   input  logic                 reset,
   input  drpec_pkg::beat_type  head,
   input  drpec_pkg::qstat_type stat,
   output logic                 pop,
   input  logic                 rsp_ready,
   output logic                 rsp_valid,
   output drpec_pkg::rsp_type   rsp
);
   import drpec_pkg::*;

   logic [LINE_CNT_BITS-1:0]   line_ff, line_in;
   logic [ROW_COUNT_BITS-1:0]  row_ff, row_in;
   logic                       fault_ff, fault_in;
   logic [FLIP_COUNT_BITS-1:0] z2o_ff, z2o_in, o2z_ff, o2z_in;
   logic                       valid_ff, valid_in;
   rsp_type                    rsp_ff, rsp_in;
   logic [LINE_CNT_BITS:0]     line_sum;
   logic [ROW_COUNT_BITS:0]    row_sum;
   logic [LINE_CNT_BITS-1:0]   line_new;
   logic [ROW_COUNT_BITS-1:0]  row_new;
   logic                       fault_new;
   logic [FLIP_COUNT_BITS-1:0] z2o_new, o2z_new;

   assign pop = !stat.empty && (!valid_ff || rsp_ready);

   always_comb begin
      line_sum  = {1'b0, line_ff} + (LINE_CNT_BITS+1)'(head.beat_errors);
      row_sum   = {1'b0, row_ff} + (ROW_COUNT_BITS+1)'(head.beat_errors);
      line_new  = line_sum[LINE_CNT_BITS] ? LINE_SUM_MAX : line_sum[LINE_CNT_BITS-1:0];
      row_new   = row_sum[ROW_COUNT_BITS] ? ROW_SUM_MAX : row_sum[ROW_COUNT_BITS-1:0];
      fault_new = fault_ff | head.faulty;
      z2o_new   = z2o_ff + FLIP_COUNT_BITS'(head.z2o);
      o2z_new   = o2z_ff + FLIP_COUNT_BITS'(head.o2z);

      line_in  = line_ff;
      row_in   = row_ff;
      fault_in = fault_ff;
      z2o_in   = z2o_ff;
      o2z_in   = o2z_ff;
      rsp_in   = rsp_ff;
      valid_in = valid_ff && !rsp_ready;
      if (pop) begin
         valid_in           = 1'b1;
         rsp_in.beat_errors = head.beat_errors;
         rsp_in.line_errors = line_new;
         rsp_in.row_errors  = ROW_OUT_BITS'(row_new);
         rsp_in.row_fault   = fault_new;
         rsp_in.row_done    = head.row_done;
         rsp_in.z2o         = FLIP_OUT_BITS'(z2o_new);
         rsp_in.o2z         = FLIP_OUT_BITS'(o2z_new);
         z2o_in   = z2o_new;
         o2z_in   = o2z_new;
         line_in  = head.line_end ? '0 : line_new;
         row_in   = head.row_done ? '0 : row_new;
         fault_in = head.row_done ? 1'b0 : fault_new;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         line_ff  <= '0;
         row_ff   <= '0;
         fault_ff <= 1'b0;
         z2o_ff   <= '0;
         o2z_ff   <= '0;
         valid_ff <= 1'b0;
      end else begin
         line_ff  <= line_in;
         row_ff   <= row_in;
         fault_ff <= fault_in;
         z2o_ff   <= z2o_in;
         o2z_ff   <= o2z_in;
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

   assign rsp_valid = valid_ff;
   assign rsp       = rsp_ff;

endmodule

### tb/sv/tb_top.sv
// self-checking testbench of the dram row pattern error counter
// depends on drpec_pkg and dram_row_pattern_error_counter; predicts every result in-line
`timescale 1ns / 1ps

module tb_top;
   import drpec_pkg::*;

   localparam int CYCLE_LIMIT = 400000;
   localparam int REPORT_LIMIT = 10;
   // index past the last register, writes to it must be ignored
   localparam logic [CSR_INDEX_BITS-1:0] CSR_UNUSED_INDEX = 2'd3;

   // how a beat's read data relates to the pattern it is checked against
   typedef enum int {
      DATA_EXACT,
      DATA_SPARSE,
      DATA_RANDOM,
      DATA_INVERTED
   } data_kind_type;

   // one result as the block should report it
   typedef struct packed {
      logic [BEAT_CNT_BITS-1:0] beat_errors;
      logic [LINE_CNT_BITS-1:0] line_errors;
      logic [ROW_OUT_BITS-1:0]  row_errors;
      logic                     row_fault;
      logic                     row_done;
      logic [FLIP_OUT_BITS-1:0] zero_to_one;
      logic [FLIP_OUT_BITS-1:0] one_to_zero;
   } beat_counts_type;

   // clock and dut ports, every input known from time zero
   logic          clock = 1'b0;
   logic          reset = 1'b1;
   logic          req_tvalid = 1'b0;
   logic          req_tready;
   logic [63:0]   req_tdata = '0;   // beat_data
   logic          req_tlast = 1'b0; // line_last_beat
   logic [1:0]    req_tuser = '0;   // row_last_line, line_faulty
   logic          rsp_tvalid;
   logic          rsp_tready = 1'b1;
   logic [103:0]  rsp_tdata;        // beat_errors, line_errors, row_errors,
                                    // flips_zero_to_one, flips_one_to_zero, zero fill
   logic          rsp_tlast;        // row_done
   logic          rsp_tuser;        // row_fault
   logic          csr_valid = 1'b0;
   logic          csr_ready;
   logic [CSR_INDEX_BITS-1:0] csr_index = '0;
   logic [CSR_DATA_BITS-1:0]  csr_data = '0;

   // register copies and running state of the predictor
   logic [7:0]                 cfg_pattern = 8'h00;
   logic                       cfg_alternate = 1'b1;
   logic                       cfg_first_inv = 1'b0;
   logic [7:0]                 cur_pattern = 8'h00;
   logic [LINE_CNT_BITS-1:0]   line_sum = '0;
   logic [ROW_COUNT_BITS-1:0]  row_sum = '0;
   logic                       row_fault_seen = 1'b0;
   logic [FLIP_COUNT_BITS-1:0] zero_to_one_total = '0;
   logic [FLIP_COUNT_BITS-1:0] one_to_zero_total = '0;

   beat_counts_type expected_counts[$];
   beat_counts_type rsp_seen;
   beat_counts_type rsp_want;

   // run bookkeeping
   int unsigned beats_sent = 0;
   int unsigned results_checked = 0;
   int unsigned csr_writes = 0;
   int unsigned rows_closed = 0;
   int unsigned mismatches = 0;
   int unsigned cycle_count = 0;
   bit          gaps_on = 1'b0;
   bit          stalls_on = 1'b0;

   dram_row_pattern_error_counter uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .rsp_tuser  (rsp_tuser),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // watchdog, a correct run stays far below this
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d results still expected",
                  cycle_count, expected_counts.size());
         $display("Some tests failed");
         $finish;
      end
   end

   // pattern of the first line of a row, inversion only counts with alternation
   function automatic void reload_pattern();
      cur_pattern = (cfg_alternate && cfg_first_inv) ? ~cfg_pattern : cfg_pattern;
   endfunction

   // register write as seen by the predictor; unknown index leaves everything alone
   function automatic void apply_csr(input logic [CSR_INDEX_BITS-1:0] idx,
                                     input logic [CSR_DATA_BITS-1:0] value);
      case (idx)
         CSR_EXPECTED_PATTERN:    cfg_pattern = value;
         CSR_ALTERNATE_LINES:     cfg_alternate = value[0];
         CSR_FIRST_LINE_INVERTED: cfg_first_inv = value[0];
         default:                 return;
      endcase
      reload_pattern();
   endfunction

   // error counts of one beat, then the line and row bookkeeping after it
   function automatic beat_counts_type count_beat_errors(input logic [63:0] data,
                                                         input logic line_end,
                                                         input logic row_last,
                                                         input logic faulty);
      beat_counts_type r;
      logic [63:0]  want;
      logic [63:0]  diff;
      int unsigned  n;
      longint unsigned lsum;
      longint unsigned rsum;
      r = '0;
      if (faulty) begin
         // a faulty beat only flags the row
         row_fault_seen = 1'b1;
      end else begin
         want = {8{cur_pattern}};
         diff = data ^ want;
         n = $countones(diff);
         r.beat_errors = BEAT_CNT_BITS'(n);
         one_to_zero_total = one_to_zero_total + $countones(diff & want);
         zero_to_one_total = zero_to_one_total + $countones(diff & ~want);
         lsum = longint'(line_sum) + n;
         line_sum = (lsum > LINE_SUM_MAX) ? LINE_SUM_MAX : LINE_CNT_BITS'(lsum);
         rsum = longint'(row_sum) + n;
         row_sum = (rsum > ROW_SUM_MAX) ? ROW_SUM_MAX : ROW_COUNT_BITS'(rsum);
      end
      r.line_errors = line_sum;
      r.row_errors  = row_sum[ROW_OUT_BITS-1:0];
      r.row_fault   = row_fault_seen;
      r.row_done    = line_end && row_last;
      r.zero_to_one = zero_to_one_total[FLIP_OUT_BITS-1:0];
      r.one_to_zero = one_to_zero_total[FLIP_OUT_BITS-1:0];
      if (line_end) begin
         line_sum = '0;
         if (cfg_alternate) begin
            cur_pattern = ~cur_pattern;
         end
      end
      if (r.row_done) begin
         row_sum = '0;
         row_fault_seen = 1'b0;
         reload_pattern();
      end
      return r;
   endfunction

   // read data relative to the pattern the next beat is checked against
   function automatic logic [63:0] make_data(input data_kind_type kind);
      logic [63:0] want;
      want = {8{cur_pattern}};
      case (kind)
         DATA_EXACT:  return want;
         DATA_SPARSE: return want ^ ({$urandom, $urandom} & {$urandom, $urandom}
                                     & {$urandom, $urandom});
         DATA_RANDOM: return {$urandom, $urandom};
         default:     return ~want;
      endcase
   endfunction

   // one request; entered and left at a falling edge, valid stays up for a follower
   task automatic send_beat(input logic [63:0] data, input logic line_end,
                            input logic row_last, input logic faulty);
      if (gaps_on && $urandom_range(0, 3) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 19)) @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= data;
      req_tlast  <= line_end;
      req_tuser  <= {faulty, row_last};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      // accepted at this edge, predict right away to keep order
      expected_counts.push_back(count_beat_errors(data, line_end, row_last, faulty));
      beats_sent++;
      if (line_end && row_last) begin
         rows_closed++;
      end
      @(negedge clock);
   endtask

   task automatic send_line(input int unsigned n_beats, input logic row_last,
                            input logic faulty);
      for (int unsigned i = 0; i < n_beats; i++) begin
         send_beat(make_data(data_kind_type'($urandom_range(0, 3))), i == n_beats - 1,
                   row_last, faulty);
      end
   endtask

   // stop sending and let every outstanding result come back
   task automatic wait_idle();
      req_tvalid <= 1'b0;
      while (expected_counts.size() != 0) @(negedge clock);
      repeat (4) @(negedge clock);
   endtask

   // only called while idle
   task automatic csr_write(input logic [CSR_INDEX_BITS-1:0] idx,
                            input logic [CSR_DATA_BITS-1:0] value);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      apply_csr(idx, value);
      csr_writes++;
      @(negedge clock);
      csr_valid <= 1'b0;
      @(negedge clock);
   endtask

   // result side backpressure in random bursts
   always begin
      @(negedge clock);
      if (stalls_on && $urandom_range(0, 7) == 0) begin
         rsp_tready <= 1'b0;
         repeat ($urandom_range(1, 19)) @(negedge clock);
      end
      rsp_tready <= 1'b1;
   end

   // result checker, compares each accepted result with the oldest prediction
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         rsp_seen.beat_errors = rsp_tdata[6:0];
         rsp_seen.line_errors = rsp_tdata[16:7];
         rsp_seen.row_errors  = rsp_tdata[32:17];
         rsp_seen.zero_to_one = rsp_tdata[64:33];
         rsp_seen.one_to_zero = rsp_tdata[96:65];
         rsp_seen.row_done    = rsp_tlast;
         rsp_seen.row_fault   = rsp_tuser;
         if (expected_counts.size() == 0) begin
            mismatches++;
            if (mismatches <= REPORT_LIMIT) begin
               $display("%0t: result with nothing outstanding: beat %0d line %0d row %0d",
                        $realtime, rsp_seen.beat_errors, rsp_seen.line_errors,
                        rsp_seen.row_errors);
            end
         end else begin
            rsp_want = expected_counts.pop_front();
            results_checked++;
            if (rsp_seen !== rsp_want) begin
               mismatches++;
               if (mismatches <= REPORT_LIMIT) begin
                  $display({"%0t: mismatch, expected beat %0d line %0d row %0d fault %0d ",
                            "done %0d z2o %0d o2z %0d / got beat %0d line %0d row %0d ",
                            "fault %0d done %0d z2o %0d o2z %0d"}, $realtime,
                           rsp_want.beat_errors, rsp_want.line_errors,
                           rsp_want.row_errors, rsp_want.row_fault, rsp_want.row_done,
                           rsp_want.zero_to_one, rsp_want.one_to_zero,
                           rsp_seen.beat_errors, rsp_seen.line_errors,
                           rsp_seen.row_errors, rsp_seen.row_fault, rsp_seen.row_done,
                           rsp_seen.zero_to_one, rsp_seen.one_to_zero);
               end
            end
         end
      end
   end

   // reset defaults: pattern 0x00 with alternation, so the second line wants 0xff
   task automatic test_reset_defaults();
      send_beat(64'h0, 1'b0, 1'b0, 1'b0);
      send_beat('1, 1'b1, 1'b0, 1'b0);
      send_beat('1, 1'b1, 1'b1, 1'b0);
      wait_idle();
   endtask

   // all-ones pattern without alternation against all-zero, mostly-one and all-one data
   task automatic test_pattern_extremes();
      csr_write(CSR_EXPECTED_PATTERN, 8'hff);
      csr_write(CSR_ALTERNATE_LINES, 8'h00);
      send_beat(64'h0, 1'b0, 1'b0, 1'b0);
      send_beat(64'h7fff_ffff_ffff_fffe, 1'b1, 1'b0, 1'b0);
      send_beat('1, 1'b1, 1'b1, 1'b0);
      wait_idle();
   endtask

   // first line inversion is ignored without alternation and applied with it
   task automatic test_first_line_polarity();
      csr_write(CSR_FIRST_LINE_INVERTED, 8'h01);
      send_beat('1, 1'b1, 1'b1, 1'b0);
      wait_idle();
      csr_write(CSR_ALTERNATE_LINES, 8'h01);
      send_beat('1, 1'b1, 1'b1, 1'b0);
      wait_idle();
   endtask

   // a write to the unused index must not touch pattern or sums
   task automatic test_unused_index();
      csr_write(CSR_UNUSED_INDEX, 8'h3c);
      send_beat({8{8'h3c}}, 1'b1, 1'b1, 1'b0);
      wait_idle();
   endtask

   // faulty line: no counts, row flagged, pattern still flips at its end
   task automatic test_faulty_line();
      csr_write(CSR_EXPECTED_PATTERN, 8'ha5);
      csr_write(CSR_FIRST_LINE_INVERTED, 8'h00);
      send_beat({$urandom, $urandom}, 1'b0, 1'b0, 1'b1);
      send_beat({$urandom, $urandom}, 1'b1, 1'b0, 1'b1);
      send_beat({8{8'h5a}}, 1'b1, 1'b1, 1'b0);
      wait_idle();
   endtask

   // overlong line of fully wrong beats pushes the line sum into saturation
   task automatic test_line_saturation();
      for (int i = 0; i < 16; i++) begin
         send_beat(make_data(DATA_INVERTED), i == 15, i == 15, 1'b0);
      end
      wait_idle();
   endtask

   // random rows of well-formed lines, with broken lines, faulty lines and noise;
   // register writes between bursts, often in the middle of a row
   task automatic test_random_rows(input int unsigned n_beats);
      int unsigned stop_at;
      int unsigned lines_left;
      int unsigned roll;
      logic [CSR_DATA_BITS-1:0] value;
      stop_at = beats_sent + n_beats;
      lines_left = 0;
      while (beats_sent < stop_at) begin
         // some bursts run without any idling
         gaps_on = ($urandom_range(0, 3) != 0);
         stalls_on = ($urandom_range(0, 3) != 0);
         repeat ($urandom_range(2, 14)) begin
            if (lines_left == 0) begin
               lines_left = $urandom_range(1, 5);
            end
            roll = $urandom_range(0, 19);
            if (roll == 0) begin
               // noise beats with arbitrary flags
               repeat ($urandom_range(1, 3)) begin
                  send_beat({$urandom, $urandom}, 1'($urandom_range(0, 1)),
                            1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
               end
            end else begin
               // wrong beat count now and then, whole faulty lines a bit more often
               send_line((roll == 1) ? $urandom_range(1, 12) : 8, lines_left == 1,
                         roll == 2 || roll == 3);
               lines_left--;
            end
         end
         wait_idle();
         repeat ($urandom_range(1, 3)) begin
            case ($urandom_range(0, 3))
               0:       value = 8'h00;
               1:       value = 8'hff;
               default: value = CSR_DATA_BITS'($urandom_range(0, 255));
            endcase
            csr_write(CSR_INDEX_BITS'($urandom_range(0, 3)), value);
         end
      end
   endtask

   // one long row of mostly wrong data drives the row sum into saturation,
   // run without idling as the last part
   task automatic test_row_saturation();
      gaps_on = 1'b0;
      stalls_on = 1'b0;
      // let a stall burst that is still running die out
      repeat (20) @(negedge clock);
      csr_write(CSR_EXPECTED_PATTERN, CSR_DATA_BITS'($urandom_range(0, 255)));
      csr_write(CSR_ALTERNATE_LINES, 8'h01);
      csr_write(CSR_FIRST_LINE_INVERTED, CSR_DATA_BITS'($urandom_range(0, 1)));
      for (int ln = 0; ln < 140; ln++) begin
         for (int b = 0; b < 8; b++) begin
            send_beat(make_data(($urandom_range(0, 9) == 0) ? DATA_RANDOM : DATA_INVERTED),
                      b == 7, ln == 139, 1'b0);
         end
      end
      wait_idle();
   endtask

   initial begin
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      test_reset_defaults();
      test_pattern_extremes();
      test_first_line_polarity();
      test_unused_index();
      test_faulty_line();
      test_line_saturation();
      test_random_rows(480);
      test_row_saturation();

      // a few more cycles so a stray extra result would still show up
      repeat (10) @(negedge clock);
      if (expected_counts.size() != 0) begin
         mismatches++;
         $display("%0d results never arrived", expected_counts.size());
      end

      $display("%0d requests in %0d rows, %0d results checked, %0d register writes",
               beats_sent, rows_closed, results_checked, csr_writes);
      $display("covered pattern extremes, alternation, faulty lines, line and row saturation");
      if (mismatches == 0) begin
         $display("All tests passed");
      end else begin
         $display("%0d mismatches", mismatches);
         $display("Some tests failed");
      end
      $finish;
   end

endmodule

### dram_row_pattern_error_counter.f
hw/rtl/drpec_pkg.sv
hw/rtl/drpec_front.sv
hw/rtl/drpec_queue.sv
hw/rtl/drpec_back.sv
hw/rtl/dram_row_pattern_error_counter.sv
tb/sv/tb_top.sv
